@@ src/mmc3_pkg.sv @@
// Shared types and constants for the MMC3-style bank mapper with scanline IRQ.
// Holds the input/result beat structs, configuration struct and decode codes.
// No dependencies.
package mmc3_pkg;

    // Item kinds carried in the func field.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_HSYNC = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;

    // Bus write address decode.
    localparam logic [15:0] ADDR_MASK   = 16'hE001;
    localparam logic [15:0] ADDR_CMD    = 16'h8000;
    localparam logic [15:0] ADDR_BANK   = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR = 16'hA000;
    localparam logic [15:0] ADDR_CNT    = 16'hC000;
    localparam logic [15:0] ADDR_LATCH  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_OFF = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ON  = 16'hE001;

    // Bank selector codes after masking the command byte.
    localparam logic [7:0] SEL_MASK     = 8'hC7;
    localparam logic [7:0] EVEN_MASK    = 8'hFE;
    localparam logic [7:0] SEL_PRG0     = 8'h06;
    localparam logic [7:0] SEL_PRG1     = 8'h07;
    localparam logic [7:0] SEL_PRG2     = 8'h46;
    localparam logic [7:0] SEL_PRG3     = 8'h47;
    localparam logic [7:0] SEL_CHR_P01  = 8'h00;
    localparam logic [7:0] SEL_CHR_P23  = 8'h01;
    localparam logic [7:0] SEL_CHR_S4   = 8'h02;
    localparam logic [7:0] SEL_CHR_S5   = 8'h03;
    localparam logic [7:0] SEL_CHR_S6   = 8'h04;
    localparam logic [7:0] SEL_CHR_S7   = 8'h05;
    localparam logic [7:0] SEL_CHR_P45  = 8'h80;
    localparam logic [7:0] SEL_CHR_P67  = 8'h81;
    localparam logic [7:0] SEL_CHR_S0   = 8'h82;
    localparam logic [7:0] SEL_CHR_S1   = 8'h83;
    localparam logic [7:0] SEL_CHR_S2   = 8'h84;
    localparam logic [7:0] SEL_CHR_S3   = 8'h85;

    // Mirroring update codes.
    localparam logic [1:0] MIRROR_NONE  = 2'd0;
    localparam logic [1:0] MIRROR_V     = 2'd1;
    localparam logic [1:0] MIRROR_H     = 2'd2;

    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_CHR_ROM     = 2'd0;
    localparam logic [1:0] CFG_PRG_COUNT   = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;
    localparam logic [8:0] PRG_COUNT_RESET = 9'd64;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        render_on;
    } in_item_t;

    typedef struct packed {
        logic [31:0] prg_banks;
        logic [31:0] chr_banks_low;
        logic [31:0] chr_banks_high;
        logic [1:0]  mirror_set;
        logic        irq_pulse;
    } out_item_t;

    typedef struct packed {
        logic       chr_rom_present;
        logic [8:0] prg_bank_count;
        logic       four_screen;
    } cfg_t;

endpackage

@@ src/mmc3_core.sv @@
// Mapper state (command, PRG/CHR bank slots, IRQ counter) and its update logic.
// Computes one result beat per item from the state left by the previous item.
// Depends on mmc3_pkg.
module mmc3_core
    import mmc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [7:0] command_reg, command_next;
    logic [7:0] prg_slot_reg [4];
    logic [7:0] prg_slot_next [4];
    logic [7:0] chr_slot_reg [8];
    logic [7:0] chr_slot_next [8];
    logic       irq_on_reg, irq_on_next;
    logic [7:0] counter_reg, counter_next;
    logic [7:0] reload_reg, reload_next;

    logic [7:0] sel;
    logic [7:0] even;
    logic [7:0] odd;
    logic [8:0] count_m2;
    logic [8:0] count_m1;
    logic [1:0] mirror;
    logic       irq;

    assign sel      = command_reg & SEL_MASK;
    assign even     = item.data & EVEN_MASK;
    assign odd      = even + 8'd1;
    assign count_m2 = cfg.prg_bank_count - 9'd2;
    assign count_m1 = cfg.prg_bank_count - 9'd1;

    always_comb
    begin
        command_next = command_reg;
        prg_slot_next = prg_slot_reg;
        chr_slot_next = chr_slot_reg;
        irq_on_next = irq_on_reg;
        counter_next = counter_reg;
        reload_next = reload_reg;
        mirror = MIRROR_NONE;
        irq = 1'b0;
        case (item.func)
            FUNC_WRITE:
            begin
                case (item.addr & ADDR_MASK)
                    ADDR_CMD:     command_next = item.data;
                    ADDR_BANK:
                    begin
                        case (sel)
                            SEL_PRG0: prg_slot_next[0] = item.data;
                            SEL_PRG1: prg_slot_next[1] = item.data;
                            SEL_PRG2: prg_slot_next[2] = item.data;
                            SEL_PRG3: prg_slot_next[3] = item.data;
                            default:
                            begin
                                if (cfg.chr_rom_present)
                                begin
                                    case (sel)
                                        SEL_CHR_P01:
                                        begin
                                            chr_slot_next[0] = even;
                                            chr_slot_next[1] = odd;
                                        end
                                        SEL_CHR_P23:
                                        begin
                                            chr_slot_next[2] = even;
                                            chr_slot_next[3] = odd;
                                        end
                                        SEL_CHR_P45:
                                        begin
                                            chr_slot_next[4] = even;
                                            chr_slot_next[5] = odd;
                                        end
                                        SEL_CHR_P67:
                                        begin
                                            chr_slot_next[6] = even;
                                            chr_slot_next[7] = odd;
                                        end
                                        SEL_CHR_S0: chr_slot_next[0] = item.data;
                                        SEL_CHR_S1: chr_slot_next[1] = item.data;
                                        SEL_CHR_S2: chr_slot_next[2] = item.data;
                                        SEL_CHR_S3: chr_slot_next[3] = item.data;
                                        SEL_CHR_S4: chr_slot_next[4] = item.data;
                                        SEL_CHR_S5: chr_slot_next[5] = item.data;
                                        SEL_CHR_S6: chr_slot_next[6] = item.data;
                                        SEL_CHR_S7: chr_slot_next[7] = item.data;
                                        default: ;
                                    endcase
                                end
                            end
                        endcase
                    end
                    ADDR_MIRROR:
                    begin
                        if (!cfg.four_screen)
                        begin
                            mirror = item.data[0] ? MIRROR_H : MIRROR_V;
                        end
                    end
                    ADDR_CNT:     counter_next = item.data;
                    ADDR_LATCH:   reload_next = item.data;
                    ADDR_IRQ_OFF: irq_on_next = 1'b0;
                    ADDR_IRQ_ON:  irq_on_next = 1'b1;
                    default: ;
                endcase
            end
            FUNC_HSYNC:
            begin
                if (irq_on_reg && (item.scanline <= LAST_VISIBLE_LINE) && item.render_on)
                begin
                    if (counter_reg == 8'd0)
                    begin
                        counter_next = reload_reg;
                        irq = 1'b1;
                    end
                    else
                    begin
                        counter_next = counter_reg - 8'd1;
                    end
                end
            end
            FUNC_RESET:
            begin
                command_next = 8'd0;
                prg_slot_next[0] = 8'd0;
                prg_slot_next[1] = 8'd1;
                prg_slot_next[2] = count_m2[7:0];
                prg_slot_next[3] = count_m1[7:0];
                // Without CHR ROM the slots come up as 0,1,0,1,0,0,0,0.
                for (int i = 0; i < 8; i++)
                begin
                    if (cfg.chr_rom_present)
                    begin
                        chr_slot_next[i] = 8'(i);
                    end
                    else
                    begin
                        chr_slot_next[i] = (i == 1 || i == 3) ? 8'd1 : 8'd0;
                    end
                end
                irq_on_next = 1'b0;
                counter_next = 8'd0;
                reload_next = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= 8'd0;
            prg_slot_reg[0] <= 8'd0;
            prg_slot_reg[1] <= 8'd1;
            prg_slot_reg[2] <= 8'(PRG_COUNT_RESET - 9'd2);
            prg_slot_reg[3] <= 8'(PRG_COUNT_RESET - 9'd1);
            for (int i = 0; i < 8; i++)
            begin
                chr_slot_reg[i] <= 8'(i);
            end
            irq_on_reg <= 1'b0;
            counter_reg <= 8'd0;
            reload_reg <= 8'd0;
        end
        else if (step)
        begin
            command_reg <= command_next;
            prg_slot_reg <= prg_slot_next;
            chr_slot_reg <= chr_slot_next;
            irq_on_reg <= irq_on_next;
            counter_reg <= counter_next;
            reload_reg <= reload_next;
        end
    end

    // The result reports the bank map as it stands after this item.
    assign result.prg_banks = {prg_slot_next[3], prg_slot_next[2],
                               prg_slot_next[1], prg_slot_next[0]};
    assign result.chr_banks_low = {chr_slot_next[3], chr_slot_next[2],
                                   chr_slot_next[1], chr_slot_next[0]};
    assign result.chr_banks_high = {chr_slot_next[7], chr_slot_next[6],
                                    chr_slot_next[5], chr_slot_next[4]};
    assign result.mirror_set = mirror;
    assign result.irq_pulse = irq;

endmodule

@@ src/mmc3_style_bank_mapper_irq.sv @@
// Top level of the MMC3-style bank mapper with scanline IRQ.
// Holds the input register, result register and configuration registers.
// Depends on mmc3_pkg and mmc3_core.
//
// Usage:
//   in_valid/in_ready carry one item per beat: a bus write, an hsync tick or
//   a mapper reset. out_valid/out_ready carry exactly one result beat per
//   item, in order, with the full bank map after that item, the mirroring
//   update it caused and whether it raised the interrupt.
//   cfg_valid/cfg_ready write register cfg_index (0 CHR ROM present,
//   1 PRG bank count, 2 four-screen) with cfg_data; cfg_ready is always high.
//   An accepted item passes through the input register and then the result
//   register before out_valid shows it. Throughput is one item per cycle
//   while out_ready stays high, with one core state update per item.
//   When the receiver stalls, the result register holds its beat and the
//   input register holds one more item; in_ready then drops.
//   Reset puts the configuration at CHR ROM present, 64 PRG banks, no
//   four-screen, and the banks at their power-on values.
module mmc3_style_bank_mapper_irq
    import mmc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    cfg_t      cfg_reg;
    logic      advance;
    out_item_t result;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chr_rom_present <= 1'b1;
            cfg_reg.prg_bank_count <= PRG_COUNT_RESET;
            cfg_reg.four_screen <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHR_ROM:     cfg_reg.chr_rom_present <= cfg_data[0];
                CFG_PRG_COUNT:   cfg_reg.prg_bank_count <= cfg_data;
                CFG_FOUR_SCREEN: cfg_reg.four_screen <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    mmc3_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A held item in the input register stays put while the core is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input register lost or changed a stalled item");

    // Every item the core commits shows up as a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("committed item produced no result beat");

    // A mirroring update and an interrupt never come from the same item, and mirror_set is never 3.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(out_item.irq_pulse && (out_item.mirror_set != MIRROR_NONE))
                       && (out_item.mirror_set != 2'd3)))
        else $error("inconsistent result flags");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the MMC3-style bank mapper with scanline IRQ.
// Feeds directed and random bus writes, hsync ticks and mapper resets, predicts each result
// beat in a local model of the mapper and compares. Depends on mmc3_pkg and the mapper RTL.
module testbench;
    import mmc3_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
    localparam logic [7:0]  SEL_UNKNOWN    = 8'hC1;
    localparam logic [15:0] ADDR_NONE      = 16'h0000;
    localparam logic [15:0] ADDR_ALIAS     = 16'h1FFE;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_AFTER     = 300;
    localparam int          PHASE_ITEMS    = 132;
    localparam int          NUM_PHASES     = 7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    // Local copy of the mapper state and its configuration.
    cfg_t       mapper_cfg;
    logic [7:0] cmd_byte;
    logic [7:0] prg_slot [4];
    logic [7:0] chr_slot [8];
    logic       irq_armed;
    logic [7:0] irq_count;
    logic [7:0] irq_reload;

    in_item_t   bus_items_q [$];
    out_item_t  bank_map_q [$];
    out_item_t  head_map;

    logic calm = 1'b0;
    logic hold_done = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   items_accepted = 0;
    int   results_checked = 0;
    int   irqs_predicted = 0;
    int   mismatch_count = 0;

    mmc3_style_bank_mapper_irq uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restore_banks();
        logic [8:0] wrapped;
        cmd_byte = '0;
        prg_slot[0] = 8'd0;
        prg_slot[1] = 8'd1;
        wrapped = mapper_cfg.prg_bank_count - 9'd2;
        prg_slot[2] = wrapped[7:0];
        wrapped = mapper_cfg.prg_bank_count - 9'd1;
        prg_slot[3] = wrapped[7:0];
        for (int i = 0; i < 8; i++)
            chr_slot[i] = mapper_cfg.chr_rom_present ? 8'(i) : 8'd0;
        if (!mapper_cfg.chr_rom_present)
        begin
            chr_slot[1] = 8'd1;
            chr_slot[3] = 8'd1;
        end
        irq_armed = 1'b0;
        irq_count = '0;
        irq_reload = '0;
    endfunction

    function automatic void set_bank(input logic [7:0] value);
        logic [7:0] sel;
        logic [7:0] even;
        sel = cmd_byte & SEL_MASK;
        even = value & EVEN_MASK;
        case (sel)
            SEL_PRG0: prg_slot[0] = value;
            SEL_PRG1: prg_slot[1] = value;
            SEL_PRG2: prg_slot[2] = value;
            SEL_PRG3: prg_slot[3] = value;
            default:
                if (mapper_cfg.chr_rom_present)
                    case (sel)
                        SEL_CHR_P01:
                        begin
                            chr_slot[0] = even;
                            chr_slot[1] = even + 8'd1;
                        end
                        SEL_CHR_P23:
                        begin
                            chr_slot[2] = even;
                            chr_slot[3] = even + 8'd1;
                        end
                        SEL_CHR_P45:
                        begin
                            chr_slot[4] = even;
                            chr_slot[5] = even + 8'd1;
                        end
                        SEL_CHR_P67:
                        begin
                            chr_slot[6] = even;
                            chr_slot[7] = even + 8'd1;
                        end
                        SEL_CHR_S0: chr_slot[0] = value;
                        SEL_CHR_S1: chr_slot[1] = value;
                        SEL_CHR_S2: chr_slot[2] = value;
                        SEL_CHR_S3: chr_slot[3] = value;
                        SEL_CHR_S4: chr_slot[4] = value;
                        SEL_CHR_S5: chr_slot[5] = value;
                        SEL_CHR_S6: chr_slot[6] = value;
                        SEL_CHR_S7: chr_slot[7] = value;
                        default: ;
                    endcase
        endcase
    endfunction

    // Applies one item to the local mapper and returns the beat it should produce.
    function automatic out_item_t next_bank_map(input in_item_t it);
        out_item_t r;
        r.mirror_set = MIRROR_NONE;
        r.irq_pulse = 1'b0;
        case (it.func)
            FUNC_WRITE:
                case (it.addr & ADDR_MASK)
                    ADDR_CMD:     cmd_byte = it.data;
                    ADDR_BANK:    set_bank(it.data);
                    ADDR_MIRROR:
                        if (!mapper_cfg.four_screen)
                            r.mirror_set = it.data[0] ? MIRROR_H : MIRROR_V;
                    ADDR_CNT:     irq_count = it.data;
                    ADDR_LATCH:   irq_reload = it.data;
                    ADDR_IRQ_OFF: irq_armed = 1'b0;
                    ADDR_IRQ_ON:  irq_armed = 1'b1;
                    default: ;
                endcase
            FUNC_HSYNC:
                if (irq_armed && it.scanline <= LAST_VISIBLE_LINE && it.render_on)
                begin
                    if (irq_count == 8'd0)
                    begin
                        irq_count = irq_reload;
                        r.irq_pulse = 1'b1;
                        irqs_predicted++;
                    end
                    else
                        irq_count = irq_count - 8'd1;
                end
            FUNC_RESET: restore_banks();
            default: ;
        endcase
        r.prg_banks      = {prg_slot[3], prg_slot[2], prg_slot[1], prg_slot[0]};
        r.chr_banks_low  = {chr_slot[3], chr_slot[2], chr_slot[1], chr_slot[0]};
        r.chr_banks_high = {chr_slot[7], chr_slot[6], chr_slot[5], chr_slot[4]};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 50)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_checked, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_item(input logic [1:0] f, input logic [15:0] a,
                                      input logic [7:0] d, input logic [8:0] line,
                                      input logic render);
        in_item_t it;
        it.func = f;
        it.addr = a;
        it.data = d;
        it.scanline = line;
        it.render_on = render;
        bus_items_q.push_back(it);
    endfunction

    function automatic void push_write(input logic [15:0] a, input logic [7:0] d);
        push_item(FUNC_WRITE, a, d, 9'($urandom), 1'($urandom));
    endfunction

    function automatic void push_hsync(input logic [8:0] line, input logic render);
        push_item(FUNC_HSYNC, 16'($urandom), 8'($urandom), line, render);
    endfunction

    // Any address in the decoded register's mirror range.
    function automatic logic [15:0] rand_addr(input logic [15:0] reg_addr);
        return reg_addr | (16'($urandom) & ADDR_ALIAS);
    endfunction

    function automatic logic [7:0] pick_selector();
        case ($urandom_range(0, 15))
            0:  return SEL_PRG0;
            1:  return SEL_PRG1;
            2:  return SEL_PRG2;
            3:  return SEL_PRG3;
            4:  return SEL_CHR_P01;
            5:  return SEL_CHR_P23;
            6:  return SEL_CHR_S4;
            7:  return SEL_CHR_S5;
            8:  return SEL_CHR_S6;
            9:  return SEL_CHR_S7;
            10: return SEL_CHR_P45;
            11: return SEL_CHR_P67;
            12: return SEL_CHR_S0;
            13: return SEL_CHR_S1;
            14: return SEL_CHR_S2;
            default: return SEL_CHR_S3;
        endcase
    endfunction

    function automatic logic [7:0] irq_value();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    // Mostly command/bank pairs and IRQ programming followed by hsyncs, plus some noise.
    function automatic void queue_random_items(input int n);
        int added;
        int kind;
        logic [7:0] cmd;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                cmd = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                  : pick_selector() | (8'($urandom) & ~SEL_MASK);
                push_write(rand_addr(ADDR_CMD), cmd);
                push_write(rand_addr(ADDR_BANK), 8'($urandom));
                added += 2;
            end
            else
            begin
                if (kind < 38)
                    push_write(rand_addr(ADDR_MIRROR) | 16'($urandom_range(0, 5) == 0),
                               8'($urandom));
                else if (kind < 50)
                    case ($urandom_range(0, 4))
                        0: push_write(rand_addr(ADDR_LATCH), irq_value());
                        1: push_write(rand_addr(ADDR_CNT), irq_value());
                        4: push_write(rand_addr(ADDR_IRQ_OFF), 8'($urandom));
                        default: push_write(rand_addr(ADDR_IRQ_ON), 8'($urandom));
                    endcase
                else if (kind < 85)
                    push_hsync(($urandom_range(0, 7) == 0) ? 9'($urandom_range(240, 511))
                                                           : 9'($urandom_range(0, 239)),
                               $urandom_range(0, 9) != 0);
                else if (kind < 89)
                    push_item(FUNC_RESET, 16'($urandom), 8'($urandom), 9'($urandom),
                              1'($urandom));
                else
                    push_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                              9'($urandom), 1'($urandom));
                added++;
            end
        end
    endfunction

    function automatic cfg_t choose_setting(input int phase);
        cfg_t s;
        s = {1'($urandom), 9'($urandom_range(0, 511)), 1'($urandom)};
        case (phase)
            0: s = {1'b1, 9'd256, 1'b0};
            1: s = {1'b0, 9'd2, 1'b1};
            2: s = {1'b0, 9'd0, 1'b0};
            3: s = {1'b1, 9'd511, 1'b1};
            4: s = {1'b1, 9'd1, 1'b0};
            default: ;
        endcase
        return s;
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [8:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CHR_ROM:     mapper_cfg.chr_rom_present = value[0];
            CFG_PRG_COUNT:   mapper_cfg.prg_bank_count = value;
            CFG_FOUR_SCREEN: mapper_cfg.four_screen = value[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (bus_items_q.size() != 0 || in_valid || bank_map_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver: offers queued items, with random gaps before an item.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            bank_map_q.push_back(next_bank_map(in_item));
            items_accepted++;
        end
        if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (bus_items_q.size() != 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 11);
                in_valid <= 1'b0;
            end
            else if (bus_items_q.size() != 0)
            begin
                in_valid <= 1'b1;
                in_item <= bus_items_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks each result beat and throttles out_ready, once for a long stretch.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (bank_map_q.size() == 0)
                report_mismatch("result beat with nothing expected, prg_banks",
                                out_item.prg_banks, '0);
            else
            begin
                head_map = bank_map_q.pop_front();
                if (out_item.prg_banks !== head_map.prg_banks)
                    report_mismatch("prg_banks", out_item.prg_banks, head_map.prg_banks);
                if (out_item.chr_banks_low !== head_map.chr_banks_low)
                    report_mismatch("chr_banks_low", out_item.chr_banks_low,
                                    head_map.chr_banks_low);
                if (out_item.chr_banks_high !== head_map.chr_banks_high)
                    report_mismatch("chr_banks_high", out_item.chr_banks_high,
                                    head_map.chr_banks_high);
                if (out_item.mirror_set !== head_map.mirror_set)
                    report_mismatch("mirror_set", 32'(out_item.mirror_set),
                                    32'(head_map.mirror_set));
                if (out_item.irq_pulse !== head_map.irq_pulse)
                    report_mismatch("irq_pulse", 32'(out_item.irq_pulse),
                                    32'(head_map.irq_pulse));
            end
            results_checked++;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_checked >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        cfg_t setting;
        mapper_cfg = {1'b1, PRG_COUNT_RESET, 1'b0};
        restore_banks();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset configuration.
        push_item(FUNC_UNUSED, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1);
        push_write(ADDR_CMD, SEL_PRG0 | ~SEL_MASK);
        push_write(ADDR_BANK, 8'hFF);
        push_write(ADDR_CMD | ADDR_ALIAS, SEL_PRG3);
        push_write(ADDR_BANK, 8'h00);
        push_write(ADDR_CMD, SEL_CHR_P01);
        push_write(ADDR_BANK | ADDR_ALIAS, 8'hFF);
        push_write(ADDR_CMD, SEL_UNKNOWN);
        push_write(ADDR_BANK, 8'h55);
        push_write(ADDR_CMD, SEL_CHR_S3);
        push_write(ADDR_BANK, 8'hAA);
        push_write(ADDR_MIRROR, 8'h01);
        push_write(ADDR_MIRROR, 8'hFE);
        push_write(ADDR_MIRROR | 16'h0001, 8'hFF);
        push_write(ADDR_LATCH, 8'd1);
        push_write(ADDR_CNT, 8'd0);
        push_write(16'hFFFF, 8'h00);
        push_hsync(9'd0, 1'b1);
        push_hsync(LAST_VISIBLE_LINE, 1'b1);
        push_hsync(LAST_VISIBLE_LINE + 9'd1, 1'b1);
        push_hsync(9'h1FF, 1'b1);
        push_hsync(9'd100, 1'b0);
        push_hsync(9'd5, 1'b1);
        push_write(ADDR_IRQ_OFF, 8'h00);
        push_write(ADDR_NONE, 8'hFF);
        push_item(FUNC_RESET, 16'h0000, 8'h00, 9'h000, 1'b0);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            setting = choose_setting(phase);
            if (phase == NUM_PHASES - 1)
                calm <= 1'b1;
            write_register(CFG_CHR_ROM, {8'($urandom), setting.chr_rom_present});
            write_register(CFG_PRG_COUNT, setting.prg_bank_count);
            write_register(CFG_FOUR_SCREEN, {8'($urandom), setting.four_screen});
            // A mapper reset first so the new bank count and CHR setting take hold.
            push_item(FUNC_RESET, 16'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end

        $display("Checked %0d result beats from %0d items under %0d register settings.",
                 results_checked, items_accepted, NUM_PHASES + 1);
        $display("%0d scanline interrupts predicted, %0d mismatches.",
                 irqs_predicted, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
